// ----- rtl/feature_token_hasher_unit_macros.svh -----
// Assertion macros used by the token hasher core.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef FEATURE_TOKEN_HASHER_UNIT_MACROS_SVH
`define FEATURE_TOKEN_HASHER_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define FTH_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define FTH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fth_pkg.sv -----
// Package for the feature token hasher: request and result payload types.
// No dependencies; imported by every module of the block.
`default_nettype none

package fth_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FEAT_W = 18;
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd32;

  // One request: a byte of the line and its end-of-line flag.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              line_last;
  } fth_in_t;

  // One result: an optional feature and the line label.
  typedef struct packed {
    logic              feature_valid;
    logic [FEAT_W-1:0] feature_index;
    logic              line_end;
    logic              label_positive;
  } fth_out_t;

endpackage

`default_nettype wire

// ----- rtl/fth_in_stage.sv -----
// Input register of the token hasher: holds one request for the core.
// Depends on fth_pkg for the request type.
`default_nettype none

module fth_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fth_pkg::fth_in_t in_data_i,
  input  wire logic           take_i,
  output logic                valid_o,
  output fth_pkg::fth_in_t    data_o
);
  import fth_pkg::*;

  logic    valid_q, valid_d;
  fth_in_t data_q;
  logic    in_fire;

  // The slot frees up in the same cycle that the core consumes it.
  assign in_ready_o = !valid_q || take_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded on each accepted request.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/fth_core.sv -----
// Tokenizer and hash core: line state registers and the per-byte update.
// Depends on fth_pkg and the assertion macros header.
`default_nettype none
`include "feature_token_hasher_unit_macros.svh"

module fth_core #(
  parameter int unsigned IndexBits = 18
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       delim_i,
  input  wire logic             fire_i,
  input  wire fth_pkg::fth_in_t req_i,
  output logic                  res_valid_o,
  output fth_pkg::fth_out_t     res_o
);
  import fth_pkg::*;

  localparam int unsigned HashSeed = 17;
  localparam logic [7:0] NS_MARK  = 8'h7C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [IndexBits-1:0] SEED = IndexBits'(HashSeed);

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Label is positive when the first two bytes read as the integer 1.
  function automatic logic label_of_head(logic [1:0] cnt, logic [7:0] b0, logic [7:0] b1);
    logic lbl;
    lbl = 1'b0;
    if (cnt == 2'd1) begin
      lbl = (b0 == CH_ONE);
    end else if (cnt == 2'd2) begin
      lbl = ((b0 == CH_ONE) && !is_digit(b1)) ||
            ((b1 == CH_ONE) && ((b0 == CH_ZERO) || (b0 == CH_PLUS) || is_ws(b0)));
    end
    return lbl;
  endfunction

  logic [IndexBits-1:0] hash_q, hash_d, seed_q, seed_d;
  logic                 inside_q, inside_d, is_ns_q, is_ns_d;
  logic                 pending_q, pending_d, halted_q, halted_d;
  logic [7:0]           head0_q, head0_d, head1_q, head1_d;
  logic [1:0]           head_cnt_q, head_cnt_d;

  logic [7:0]           c;
  logic                 last, live, is_zero, is_delim, fold, start, close, feat;
  logic [IndexBits-1:0] hash_base, hash_fold, hash_n, ext;
  logic                 inside_n, is_ns_n;
  logic [1:0]           head_cnt_n;
  logic [7:0]           head0_n, head1_n;
  logic                 res_plain, line_idle;

  // Byte classification.
  assign c        = req_i.data_byte;
  assign last     = req_i.line_last;
  assign live     = !halted_q;
  assign is_zero  = (c == 8'd0);
  assign is_delim = (c == delim_i);
  assign fold     = live && !is_zero && !is_delim;
  assign start    = fold && !inside_q;
  assign ext      = IndexBits'($signed(c));

  // Hash fold: h*31 + c as a shift, a subtract and an add.
  always_comb begin
    if (start) begin
      hash_base = (c == NS_MARK) ? SEED : seed_q;
    end else begin
      hash_base = hash_q;
    end
    hash_fold = (hash_base << 5) - hash_base + ext;
    hash_n    = fold ? hash_fold : hash_q;
    inside_n  = inside_q || start;
    is_ns_n   = start ? (c == NS_MARK) : is_ns_q;
  end

  // Token close on delimiter, zero byte or end of line.
  assign close = inside_n && ((live && (is_zero || is_delim)) || last);
  assign feat  = close && !is_ns_n && !pending_q;

  // Capture of the first two bytes of the line for the label.
  always_comb begin
    head0_n    = head0_q;
    head1_n    = head1_q;
    head_cnt_n = head_cnt_q;
    if (live && !is_zero && head_cnt_q != 2'd2) begin
      if (head_cnt_q == 2'd0) begin
        head0_n = c;
      end else begin
        head1_n = c;
      end
      head_cnt_n = head_cnt_q + 2'd1;
    end
  end

  // Result of this byte.
  always_comb begin
    res_valid_o          = feat || last;
    res_o.feature_valid  = feat;
    res_o.feature_index  = feat ? FEAT_W'(hash_n) : '0;
    res_o.line_end       = last;
    res_o.label_positive = last ? label_of_head(head_cnt_n, head0_n, head1_n) : 1'b0;
  end

  // Next line state; everything returns to its start value after the last byte.
  always_comb begin
    hash_d     = hash_q;
    seed_d     = seed_q;
    inside_d   = inside_q;
    is_ns_d    = is_ns_q;
    pending_d  = pending_q;
    halted_d   = halted_q;
    head0_d    = head0_q;
    head1_d    = head1_q;
    head_cnt_d = head_cnt_q;
    if (fire_i) begin
      if (last) begin
        hash_d     = SEED;
        seed_d     = SEED;
        inside_d   = 1'b0;
        is_ns_d    = 1'b0;
        pending_d  = 1'b1;
        halted_d   = 1'b0;
        head0_d    = '0;
        head1_d    = '0;
        head_cnt_d = '0;
      end else begin
        hash_d     = hash_n;
        inside_d   = inside_n && !close;
        is_ns_d    = is_ns_n;
        halted_d   = halted_q || (live && is_zero);
        head0_d    = head0_n;
        head1_d    = head1_n;
        head_cnt_d = head_cnt_n;
        if (close && is_ns_n) begin
          seed_d = hash_n;
        end
        if (close && !is_ns_n) begin
          pending_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q     <= SEED;
      seed_q     <= SEED;
      inside_q   <= 1'b0;
      is_ns_q    <= 1'b0;
      pending_q  <= 1'b1;
      halted_q   <= 1'b0;
      head0_q    <= '0;
      head1_q    <= '0;
      head_cnt_q <= '0;
    end else begin
      hash_q     <= hash_d;
      seed_q     <= seed_d;
      inside_q   <= inside_d;
      is_ns_q    <= is_ns_d;
      pending_q  <= pending_d;
      halted_q   <= halted_d;
      head0_q    <= head0_d;
      head1_q    <= head1_d;
      head_cnt_q <= head_cnt_d;
    end
  end

  // Terms for the checks below: a consumed result that does not end the line,
  // and the line state at its start value.
  assign res_plain = fire_i && res_valid_o && !res_o.line_end;
  assign line_idle = !inside_q && pending_q && !halted_q && (head_cnt_q == 2'd0);

  // A result without line end must carry a feature.
  `FTH_ASSERT_IMP(a_res_has_cause, res_plain, res_o.feature_valid, "result without cause")
  // The line state is back at its start after the last byte of a line.
  `FTH_ASSERT_NEXT(a_line_clear, fire_i && last, line_idle, "line state not cleared")
  // After a zero byte no token may be open.
  `FTH_ASSERT_IMP(a_halt_closed, halted_q, !inside_q, "token open after zero byte")

endmodule

`default_nettype wire

// ----- rtl/fth_out_stage.sv -----
// Output register of the token hasher: holds one result until taken.
// Depends on fth_pkg for the result type.
`default_nettype none

module fth_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire fth_pkg::fth_out_t data_i,
  output logic                   can_take_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fth_pkg::fth_out_t      out_data_o
);
  import fth_pkg::*;

  logic     valid_q, valid_d;
  fth_out_t data_q;

  // A new result may enter when the slot is empty or is read this cycle.
  assign can_take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/feature_token_hasher_unit.sv -----
// Top level of the feature token hasher: delimiter register and the three stages.
// Depends on fth_pkg, fth_in_stage, fth_core and fth_out_stage.
//
//   Port group  Direction  Handshake            Payload
//   in_*        request    in_valid/in_ready    fth_in_t (data_byte, line_last)
//   out_*       result     out_valid/out_ready  fth_out_t (feature, line end, label)
//   cfg_*       write      cfg_we, no wait      delimiter byte
//
// One byte is taken every cycle while the result register has room; a result passes
// from the input register through the single hash fold h*31 + c into the result register.
// Bytes that finish no token and do not end the line give no result.
// Reset clears the delimiter to a space and the line state to its start.
// A stalled result register holds the input register, which then holds the request port.
`default_nettype none

module feature_token_hasher_unit #(
  parameter int unsigned INDEX_BITS = 18
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fth_pkg::fth_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fth_pkg::fth_out_t      out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i
);
  import fth_pkg::*;

  logic [7:0] delim_q;
  logic       s1_valid, fire, out_can_take, res_valid;
  fth_in_t    s1_data;
  fth_out_t   res;

  // Delimiter configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  // The core consumes the held request when the result register has room.
  assign fire = s1_valid && out_can_take;

  fth_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (fire),
    .valid_o    (s1_valid),
    .data_o     (s1_data)
  );

  fth_core #(
    .IndexBits (INDEX_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .delim_i     (delim_q),
    .fire_i      (fire),
    .req_i       (s1_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fth_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res_valid),
    .data_i      (res),
    .can_take_o  (out_can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
